// ===== sv/sorted_merge_sum_equal_keys_unit_defines.svh =====
// assertion macros for the sorted merge unit checker
// used only by the checker file, no other dependencies
`ifndef SORTED_MERGE_SUM_EQUAL_KEYS_UNIT_DEFINES_SVH
`define SORTED_MERGE_SUM_EQUAL_KEYS_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SMSEK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smsek checker: same-cycle rule violated");

// next-cycle implication, disabled in reset
`define SMSEK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smsek checker: next-cycle rule violated");

`endif

// ===== sv/smsek_pkg.sv =====
// shared types and constants for the sorted merge unit
// no dependencies
`default_nettype none

package smsek_pkg;

    localparam int TIME_W = 40;
    localparam int INT_W  = 32;
    localparam int KEY_W  = 31;

    // per-list peak queue
    localparam int QUEUE_DEPTH = 16;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // request queue between front and back
    localparam int IFIFO_DEPTH = 4;
    localparam int IF_IDX_W    = $clog2(IFIFO_DEPTH);
    localparam int IF_CNT_W    = $clog2(IFIFO_DEPTH + 1);

    // key = (t + 500) / 1000 = ((t + 500) >> 3) / 125, the latter by reciprocal
    localparam logic [TIME_W:0] KEY_ROUND = 41'd500;
    localparam int X_W     = 38;
    localparam int XL_W    = 19;
    localparam int XH_W    = X_W - XL_W;
    localparam int RL_W    = 20;
    localparam int RH_W    = 19;
    localparam logic [RL_W+RH_W-1:0] KEY_RECIP = 39'd281474976711;  // ceil(2^45 / 125)
    localparam int KEY_SHIFT = 45;
    localparam int PROD_W    = X_W + RL_W + RH_W;

    typedef enum logic [1:0] {
        OP_PEAK_A,
        OP_END_A,
        OP_PEAK_B,
        OP_END_B
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [TIME_W-1:0]  time_us;
        logic [INT_W-1:0]   intensity;
        logic [KEY_W-1:0]   key;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_item_push;

    typedef struct packed {
        logic [TIME_W-1:0]  time_us;
        logic [INT_W-1:0]   intensity;
        logic [KEY_W-1:0]   key;
    } t_peak;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DECIDE
    } t_back_state;

endpackage

`default_nettype wire

// ===== sv/smsek_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module smsek_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/smsek_front.sv =====
// front end: decodes each request and computes its millisecond key
// depends on smsek_pkg
`default_nettype none

module smsek_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_list_select,
    input  logic                           i_end_of_list,
    input  logic [smsek_pkg::TIME_W-1:0]   i_peak_time,
    input  logic [smsek_pkg::INT_W-1:0]    i_peak_intensity,
    output logic                           o_stall,
    output smsek_pkg::t_item_push          o_push,
    input  logic                           i_full
);

    smsek_pkg::t_op                       in_op;
    logic [smsek_pkg::TIME_W:0]           rounded;
    logic                                 adv;
    logic [smsek_pkg::PROD_W-1:0]         prod;

    logic                                 r_s1_valid;
    smsek_pkg::t_op                       r_s1_op;
    logic [smsek_pkg::TIME_W-1:0]         r_s1_time;
    logic [smsek_pkg::INT_W-1:0]          r_s1_int;
    logic [smsek_pkg::X_W-1:0]            r_s1_x;

    logic                                 r_s2_valid;
    smsek_pkg::t_op                       r_s2_op;
    logic [smsek_pkg::TIME_W-1:0]         r_s2_time;
    logic [smsek_pkg::INT_W-1:0]          r_s2_int;
    logic [smsek_pkg::XH_W+smsek_pkg::RH_W-1:0] r_s2_p_hh;
    logic [smsek_pkg::XH_W+smsek_pkg::RL_W-1:0] r_s2_p_hl;
    logic [smsek_pkg::XL_W+smsek_pkg::RH_W-1:0] r_s2_p_lh;
    logic [smsek_pkg::XL_W+smsek_pkg::RL_W-1:0] r_s2_p_ll;

    logic                                 r_s3_valid;
    smsek_pkg::t_op                       r_s3_op;
    logic [smsek_pkg::TIME_W-1:0]         r_s3_time;
    logic [smsek_pkg::INT_W-1:0]          r_s3_int;
    logic [smsek_pkg::XH_W+smsek_pkg::RH_W-1:0] r_s3_p_hh;
    logic [58:0]                          r_s3_mid;
    logic [smsek_pkg::XL_W+smsek_pkg::RL_W-1:0] r_s3_p_ll;

    always_comb begin
        unique case ({i_list_select, i_end_of_list})
            2'b00:   in_op = smsek_pkg::OP_PEAK_A;
            2'b01:   in_op = smsek_pkg::OP_END_A;
            2'b10:   in_op = smsek_pkg::OP_PEAK_B;
            2'b11:   in_op = smsek_pkg::OP_END_B;
            default: in_op = smsek_pkg::OP_PEAK_A;
        endcase
    end

    assign rounded = {1'b0, i_peak_time} + smsek_pkg::KEY_ROUND;
    assign adv     = !(r_s3_valid && i_full);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op   <= in_op;
            r_s1_time <= i_peak_time;
            r_s1_int  <= i_peak_intensity;
            r_s1_x    <= rounded[smsek_pkg::TIME_W:3];

            // partial products of x * recip, each under 20 x 20 bits
            r_s2_op   <= r_s1_op;
            r_s2_time <= r_s1_time;
            r_s2_int  <= r_s1_int;
            r_s2_p_hh <= {{smsek_pkg::RH_W{1'b0}}, r_s1_x[smsek_pkg::X_W-1:smsek_pkg::XL_W]}
                       * {{smsek_pkg::XH_W{1'b0}},
                          smsek_pkg::KEY_RECIP[smsek_pkg::RL_W+smsek_pkg::RH_W-1:smsek_pkg::RL_W]};
            r_s2_p_hl <= {{smsek_pkg::RL_W{1'b0}}, r_s1_x[smsek_pkg::X_W-1:smsek_pkg::XL_W]}
                       * {{smsek_pkg::XH_W{1'b0}}, smsek_pkg::KEY_RECIP[smsek_pkg::RL_W-1:0]};
            r_s2_p_lh <= {{smsek_pkg::RH_W{1'b0}}, r_s1_x[smsek_pkg::XL_W-1:0]}
                       * {{smsek_pkg::XL_W{1'b0}},
                          smsek_pkg::KEY_RECIP[smsek_pkg::RL_W+smsek_pkg::RH_W-1:smsek_pkg::RL_W]};
            r_s2_p_ll <= {{smsek_pkg::RL_W{1'b0}}, r_s1_x[smsek_pkg::XL_W-1:0]}
                       * {{smsek_pkg::XL_W{1'b0}}, smsek_pkg::KEY_RECIP[smsek_pkg::RL_W-1:0]};

            r_s3_op   <= r_s2_op;
            r_s3_time <= r_s2_time;
            r_s3_int  <= r_s2_int;
            r_s3_p_hh <= r_s2_p_hh;
            r_s3_mid  <= {1'b0, r_s2_p_hl, 19'b0} + {1'b0, r_s2_p_lh, 20'b0};
            r_s3_p_ll <= r_s2_p_ll;
        end
    end

    assign prod = {r_s3_p_hh, 39'b0} + {18'b0, r_s3_mid} + {38'b0, r_s3_p_ll};

    always_comb begin
        o_push.valid          = r_s3_valid && adv;
        o_push.item.op        = r_s3_op;
        o_push.item.time_us   = r_s3_time;
        o_push.item.intensity = r_s3_int;
        o_push.item.key       = prod[smsek_pkg::KEY_SHIFT+smsek_pkg::KEY_W-1:smsek_pkg::KEY_SHIFT];
    end

endmodule

`default_nettype wire

// ===== sv/smsek_ififo.sv =====
// short request queue between the front end and the merge engine
// depends on smsek_pkg
`default_nettype none

module smsek_ififo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  smsek_pkg::t_item_push  i_push,
    output logic                   o_full,
    output logic                   o_valid,
    output smsek_pkg::t_item       o_item,
    input  logic                   i_pop
);

    smsek_pkg::t_item                 r_mem [smsek_pkg::IFIFO_DEPTH];
    logic [smsek_pkg::IF_IDX_W-1:0]   r_wptr;
    logic [smsek_pkg::IF_IDX_W-1:0]   r_rptr;
    logic [smsek_pkg::IF_CNT_W-1:0]   r_count;
    logic                             do_pop;

    assign o_full  = (r_count == smsek_pkg::IF_CNT_W'(smsek_pkg::IFIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + smsek_pkg::IF_IDX_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + smsek_pkg::IF_IDX_W'(1);
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + smsek_pkg::IF_CNT_W'(1);
            end else if (!i_push.valid && do_pop) begin
                r_count <= r_count - smsek_pkg::IF_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/smsek_back.sv =====
// merge engine: per-list peak queues in ram, head compare, result register
// depends on smsek_pkg and smsek_ram
`default_nettype none

module smsek_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  smsek_pkg::t_item              i_item,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [smsek_pkg::TIME_W-1:0]  o_merged_time,
    output logic [smsek_pkg::INT_W-1:0]   o_merged_intensity,
    output logic                          o_is_last,
    output logic                          o_no_peaks,
    output logic                          o_overflow
);

    localparam int PEAK_W = $bits(smsek_pkg::t_peak);

    function automatic logic [smsek_pkg::Q_IDX_W-1:0] slot_of(
        input logic [smsek_pkg::Q_IDX_W-1:0] head,
        input logic [smsek_pkg::Q_CNT_W-1:0] cnt
    );
        logic [smsek_pkg::Q_CNT_W:0] s;
        s = (smsek_pkg::Q_CNT_W+1)'(head) + {1'b0, cnt};
        if (s >= (smsek_pkg::Q_CNT_W+1)'(smsek_pkg::QUEUE_DEPTH)) begin
            s = s - (smsek_pkg::Q_CNT_W+1)'(smsek_pkg::QUEUE_DEPTH);
        end
        return s[smsek_pkg::Q_IDX_W-1:0];
    endfunction

    function automatic logic [smsek_pkg::Q_IDX_W-1:0] next_idx(
        input logic [smsek_pkg::Q_IDX_W-1:0] idx
    );
        logic [smsek_pkg::Q_IDX_W-1:0] r;
        if (idx == smsek_pkg::Q_IDX_W'(smsek_pkg::QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = idx + smsek_pkg::Q_IDX_W'(1);
        end
        return r;
    endfunction

    smsek_pkg::t_back_state          r_state, n_state;
    logic [smsek_pkg::Q_CNT_W-1:0]   r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [smsek_pkg::Q_IDX_W-1:0]   r_head_a, n_head_a, r_head_b, n_head_b;
    logic [1:0]                      r_ended, n_ended;
    logic                            r_ovf, n_ovf;
    logic                            r_any, n_any;

    logic                            r_out_valid, n_out_valid;
    logic [smsek_pkg::TIME_W-1:0]    r_out_time, n_out_time;
    logic [smsek_pkg::INT_W-1:0]     r_out_int, n_out_int;
    logic                            r_out_last, n_out_last;
    logic                            r_out_none, n_out_none;
    logic                            r_out_ovf, n_out_ovf;

    logic                            we_a, we_b;
    logic [PEAK_W-1:0]               wdata;
    logic [PEAK_W-1:0]               rdata_a, rdata_b;
    smsek_pkg::t_peak                peak_a, peak_b;

    logic                            ea, eb, has_a, has_b;
    logic                            take_a, take_b;
    logic [smsek_pkg::Q_CNT_W:0]     remain;
    logic                            step_ok, is_last;
    logic [smsek_pkg::INT_W:0]       sum;
    logic [smsek_pkg::INT_W-1:0]     res_int;
    logic                            out_free;

    assign wdata = {i_item.time_us, i_item.intensity, i_item.key};

    smsek_ram #(
        .WIDTH (PEAK_W),
        .DEPTH (smsek_pkg::QUEUE_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (slot_of(r_head_a, r_cnt_a)),
        .i_wdata (wdata),
        .i_raddr (r_head_a),
        .o_rdata (rdata_a)
    );

    smsek_ram #(
        .WIDTH (PEAK_W),
        .DEPTH (smsek_pkg::QUEUE_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (slot_of(r_head_b, r_cnt_b)),
        .i_wdata (wdata),
        .i_raddr (r_head_b),
        .o_rdata (rdata_b)
    );

    assign peak_a = rdata_a;
    assign peak_b = rdata_b;

    // head selection and hold-back rule
    always_comb begin
        ea     = r_ended[0];
        eb     = r_ended[1];
        has_a  = (r_cnt_a != '0);
        has_b  = (r_cnt_b != '0);
        take_a = 1'b0;
        take_b = 1'b0;
        if (has_a && has_b) begin
            take_a = !(peak_b.key < peak_a.key);
            take_b = !(peak_a.key < peak_b.key);
        end else if (has_a && eb) begin
            take_a = 1'b1;
        end else if (has_b && ea) begin
            take_b = 1'b1;
        end
        remain  = {1'b0, r_cnt_a} + {1'b0, r_cnt_b}
                - (smsek_pkg::Q_CNT_W+1)'(take_a) - (smsek_pkg::Q_CNT_W+1)'(take_b);
        // before both ends keep one peak back so the final result can be marked
        step_ok = (take_a || take_b) && ((ea && eb) || (remain != '0));
        is_last = ea && eb && (remain == '0);
        sum     = {1'b0, peak_a.intensity} + {1'b0, peak_b.intensity};
        if (take_a && take_b) begin
            res_int = sum[smsek_pkg::INT_W] ? '1 : sum[smsek_pkg::INT_W-1:0];
        end else if (take_a) begin
            res_int = peak_a.intensity;
        end else begin
            res_int = peak_b.intensity;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_head_a    = r_head_a;
        n_head_b    = r_head_b;
        n_ended     = r_ended;
        n_ovf       = r_ovf;
        n_any       = r_any;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_time  = r_out_time;
        n_out_int   = r_out_int;
        n_out_last  = r_out_last;
        n_out_none  = r_out_none;
        n_out_ovf   = r_out_ovf;
        o_pop       = 1'b0;
        we_a        = 1'b0;
        we_b        = 1'b0;

        unique case (r_state)
            smsek_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_state = smsek_pkg::ST_READ;
                    unique case (i_item.op)
                        smsek_pkg::OP_PEAK_A: begin
                            if (!r_ended[0]) begin
                                if (r_cnt_a == smsek_pkg::Q_CNT_W'(smsek_pkg::QUEUE_DEPTH)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    we_a    = 1'b1;
                                    n_cnt_a = r_cnt_a + smsek_pkg::Q_CNT_W'(1);
                                end
                            end
                        end
                        smsek_pkg::OP_PEAK_B: begin
                            if (!r_ended[1]) begin
                                if (r_cnt_b == smsek_pkg::Q_CNT_W'(smsek_pkg::QUEUE_DEPTH)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    we_b    = 1'b1;
                                    n_cnt_b = r_cnt_b + smsek_pkg::Q_CNT_W'(1);
                                end
                            end
                        end
                        smsek_pkg::OP_END_A: n_ended[0] = 1'b1;
                        smsek_pkg::OP_END_B: n_ended[1] = 1'b1;
                        default: n_ended = r_ended;
                    endcase
                end
            end
            smsek_pkg::ST_READ: begin
                // the ram read is registered, so its output follows the head registers in the next cycle
                n_state = smsek_pkg::ST_DECIDE;
            end
            smsek_pkg::ST_DECIDE: begin
                if (ea && eb && !has_a && !has_b) begin
                    if (r_any || out_free) begin
                        if (!r_any) begin
                            n_out_valid = 1'b1;
                            n_out_time  = '0;
                            n_out_int   = '0;
                            n_out_last  = 1'b1;
                            n_out_none  = 1'b1;
                            n_out_ovf   = r_ovf;
                        end
                        n_cnt_a  = '0;
                        n_cnt_b  = '0;
                        n_head_a = '0;
                        n_head_b = '0;
                        n_ended  = '0;
                        n_ovf    = 1'b0;
                        n_any    = 1'b0;
                        n_state  = smsek_pkg::ST_IDLE;
                    end
                end else if (!step_ok) begin
                    n_state = smsek_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_time  = take_a ? peak_a.time_us : peak_b.time_us;
                    n_out_int   = res_int;
                    n_out_last  = is_last;
                    n_out_none  = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_any       = 1'b1;
                    if (take_a) begin
                        n_head_a = next_idx(r_head_a);
                        n_cnt_a  = r_cnt_a - smsek_pkg::Q_CNT_W'(1);
                    end
                    if (take_b) begin
                        n_head_b = next_idx(r_head_b);
                        n_cnt_b  = r_cnt_b - smsek_pkg::Q_CNT_W'(1);
                    end
                    n_state = smsek_pkg::ST_READ;
                    if (is_last) begin
                        n_cnt_a  = '0;
                        n_cnt_b  = '0;
                        n_head_a = '0;
                        n_head_b = '0;
                        n_ended  = '0;
                        n_ovf    = 1'b0;
                        n_any    = 1'b0;
                        n_state  = smsek_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = smsek_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smsek_pkg::ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_head_a    <= '0;
            r_head_b    <= '0;
            r_ended     <= '0;
            r_ovf       <= 1'b0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_head_a    <= n_head_a;
            r_head_b    <= n_head_b;
            r_ended     <= n_ended;
            r_ovf       <= n_ovf;
            r_any       <= n_any;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_time <= n_out_time;
        r_out_int  <= n_out_int;
        r_out_last <= n_out_last;
        r_out_none <= n_out_none;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_out_valid        = r_out_valid;
    assign o_merged_time      = r_out_time;
    assign o_merged_intensity = r_out_int;
    assign o_is_last          = r_out_last;
    assign o_no_peaks         = r_out_none;
    assign o_overflow         = r_out_ovf;

endmodule

`default_nettype wire

// ===== sv/sorted_merge_sum_equal_keys_unit.sv =====
// top level of the sorted peak-list merge unit
// depends on smsek_pkg, smsek_front, smsek_ififo, smsek_back
//
//  channel  dir  handshake                 payload
//  in       in   i_in_valid / o_in_stall   list_select, end_of_list, peak_time, peak_intensity
//  out      out  o_out_valid / i_out_stall merged_time, merged_intensity, is_last, no_peaks,
//                                          overflow
//
// a request passes the front end's registered stages (round add, partial products, sum)
// before it reaches a 4-entry request queue; the merge engine takes one request at a time
// through its idle, read and decide states and, after each result but a merge's final one,
// returns through read, for the registered peak ram read, and decide, for the key compare
// reset is synchronous; it clears control state only, the peak rams hold no reset value
// o_in_stall rises when the request queue is full and the last front stage holds;
// a valid result holds in the result register while i_out_stall is high
`default_nettype none

module sorted_merge_sum_equal_keys_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_list_select,
    input  logic                          i_end_of_list,
    input  logic [smsek_pkg::TIME_W-1:0]  i_peak_time,
    input  logic [smsek_pkg::INT_W-1:0]   i_peak_intensity,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [smsek_pkg::TIME_W-1:0]  o_merged_time,
    output logic [smsek_pkg::INT_W-1:0]   o_merged_intensity,
    output logic                          o_is_last,
    output logic                          o_no_peaks,
    output logic                          o_overflow
);

    smsek_pkg::t_item_push  push;
    logic                   fifo_full;
    logic                   fifo_valid;
    smsek_pkg::t_item       fifo_item;
    logic                   fifo_pop;

    smsek_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .i_list_select    (i_list_select),
        .i_end_of_list    (i_end_of_list),
        .i_peak_time      (i_peak_time),
        .i_peak_intensity (i_peak_intensity),
        .o_stall          (o_in_stall),
        .o_push           (push),
        .i_full           (fifo_full)
    );

    smsek_ififo u_ififo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_item  (fifo_item),
        .i_pop   (fifo_pop)
    );

    smsek_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item_valid       (fifo_valid),
        .i_item             (fifo_item),
        .o_pop              (fifo_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_merged_time      (o_merged_time),
        .o_merged_intensity (o_merged_intensity),
        .o_is_last          (o_is_last),
        .o_no_peaks         (o_no_peaks),
        .o_overflow         (o_overflow)
    );

endmodule

`default_nettype wire

// ===== sv/smsek_checker.sv =====
// port-level checks for the sorted merge unit, bound to the top level
// depends on smsek_pkg and the defines header
`default_nettype none
`include "sorted_merge_sum_equal_keys_unit_defines.svh"

module smsek_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [smsek_pkg::TIME_W-1:0]  o_merged_time,
    input logic [smsek_pkg::INT_W-1:0]   o_merged_intensity,
    input logic                          o_is_last,
    input logic                          o_no_peaks,
    input logic                          o_overflow
);

    // a stalled result holds
    `SMSEK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_merged_time) && $stable(o_merged_intensity)
        && $stable(o_is_last))

    // the empty-merge result is the last one and carries zero fields
    `SMSEK_ASSERT_NOW(a_empty_fields, i_clk, i_rst_n, o_out_valid && o_no_peaks,
        o_is_last && (o_merged_time == '0) && (o_merged_intensity == '0))

    // a dropped peak means the queue was full, so the merge cannot be empty
    `SMSEK_ASSERT_NOW(a_empty_no_ovf, i_clk, i_rst_n, o_out_valid && o_no_peaks, !o_overflow)

    // overflow is sticky within a merge
    `SMSEK_ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && o_overflow && !o_is_last, !o_out_valid || o_overflow)

endmodule

bind sorted_merge_sum_equal_keys_unit smsek_checker u_checker (.*);

`default_nettype wire
